>>> src/assert_macros.svh
// assertion macros shared by the decoder modules
// no dependencies; checks compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define UTF8D_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("utf8 decoder check failed");
// condition must never be seen outside reset
`define UTF8D_NEVER(label, clk, rstn, cond) \
    `UTF8D_ASSERT(label, clk, rstn, !(cond))
`else
`define UTF8D_ASSERT(label, clk, rstn, prop)
`define UTF8D_NEVER(label, clk, rstn, cond)
`endif
`endif

>>> src/utf8d_pkg.sv
// shared types, status codes and lead byte decode for the utf8 stream decoder
// no dependencies
package utf8d_pkg;

    localparam int unsigned CpWidth    = 31;
    localparam int unsigned LenWidth   = 3;
    localparam int unsigned OutPayload = CpWidth + LenWidth;
    localparam int unsigned OutTdataW  = ((OutPayload + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_BAD_CONT = 2'd2,
        ST_TRUNC    = 2'd3
    } status_t;

    // one input word as held by the input register
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    // one decoded result word
    typedef struct packed {
        logic [CpWidth-1:0]  code_point;
        logic [LenWidth-1:0] seq_length;
        status_t             status;
    } result_t;

    // sequence length from a lead byte, zero for an illegal lead
    function automatic logic [LenWidth-1:0] lead_length(input logic [7:0] b);
        logic [LenWidth-1:0] n;
        case (b) inside
            8'b0???????: n = 3'd1;
            8'b110?????: n = 3'd2;
            8'b1110????: n = 3'd3;
            8'b11110???: n = 3'd4;
            8'b111110??: n = 3'd5;
            8'b1111110?: n = 3'd6;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

>>> src/utf8d_in_stage.sv
// input register of the utf8 stream decoder
// depends on utf8d_pkg
module utf8d_in_stage import utf8d_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  in_item_t s_item,
    input  logic     down_ready,
    output logic     item_valid,
    output in_item_t item,
    output logic     advance
);

    logic     valid_reg, valid_next;
    in_item_t item_reg;

    // word moves on whenever the output side has room
    assign advance  = valid_reg && down_ready;
    assign s_tready = !valid_reg || down_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> src/utf8d_core.sv
// sequence state and single-pass decode of one byte
// depends on utf8d_pkg and assert_macros.svh
`include "assert_macros.svh"
module utf8d_core import utf8d_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     advance,
    input  in_item_t item,
    output logic     res_valid,
    output result_t  res
);

    logic [CpWidth-1:0]  acc_reg, acc_next;
    logic [LenWidth-1:0] rem_reg, rem_next;
    logic [LenWidth-1:0] seq_reg, seq_next;

    logic [7:0]          b;
    logic [LenWidth-1:0] n;
    logic [LenWidth-1:0] received;
    logic [LenWidth-1:0] rem_dec;
    logic [CpWidth-1:0]  acc_shift;
    logic [6:0]          lead_mask;

    assign b         = item.in_byte;
    assign n         = lead_length(b);
    assign received  = seq_reg - rem_reg;
    assign rem_dec   = rem_reg - 3'd1;
    assign acc_shift = {acc_reg[CpWidth-7:0], b[5:0]};
    assign lead_mask = 7'h7F >> n;

    // decode of the current byte against the sequence state
    always_comb begin
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        seq_next       = seq_reg;
        res_valid      = 1'b0;
        res.code_point = '0;
        res.seq_length = 3'd1;
        res.status     = ST_OK;
        if (rem_reg == 3'd0) begin
            // idle: byte is a lead
            if (n == 3'd0) begin
                res_valid  = 1'b1;
                res.status = ST_BAD_LEAD;
            end else if (n == 3'd1) begin
                res_valid      = 1'b1;
                res.code_point = {{(CpWidth-8){1'b0}}, b};
            end else if (item.end_of_input) begin
                res_valid  = 1'b1;
                res.status = ST_TRUNC;
            end else begin
                acc_next = {{(CpWidth-7){1'b0}}, b[6:0] & lead_mask};
                rem_next = n - 3'd1;
                seq_next = n;
            end
        end else if (b[7:6] != 2'b10) begin
            // bad continuation drops the sequence and this byte
            res_valid      = 1'b1;
            res.seq_length = received + 3'd1;
            res.status     = ST_BAD_CONT;
            acc_next       = '0;
            rem_next       = '0;
            seq_next       = '0;
        end else if (rem_dec == 3'd0) begin
            // last continuation completes the character
            res_valid      = 1'b1;
            res.code_point = acc_shift;
            res.seq_length = seq_reg;
            acc_next       = '0;
            rem_next       = '0;
            seq_next       = '0;
        end else if (item.end_of_input) begin
            res_valid      = 1'b1;
            res.seq_length = received + 3'd1;
            res.status     = ST_TRUNC;
            acc_next       = '0;
            rem_next       = '0;
            seq_next       = '0;
        end else begin
            acc_next = acc_shift;
            rem_next = rem_dec;
        end
    end

    // sequence state, updated only when a word is consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            rem_reg <= '0;
            seq_reg <= '0;
        end else if (advance) begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
            seq_reg <= seq_next;
        end
    end

    // checks on the sequence state and results
    `UTF8D_NEVER(a_rem_range, aclk, aresetn, rem_reg > 3'd5)
    `UTF8D_ASSERT(a_seq_above_rem, aclk, aresetn,
                  (rem_reg != 3'd0) |-> (seq_reg > rem_reg && seq_reg <= 3'd6))
    `UTF8D_ASSERT(a_err_zero_cp, aclk, aresetn,
                  (res_valid && res.status != ST_OK) |-> (res.code_point == '0))
    `UTF8D_ASSERT(a_len_range, aclk, aresetn,
                  res_valid |-> (res.seq_length >= 3'd1 && res.seq_length <= 3'd6))

endmodule

>>> src/utf8d_out_stage.sv
// output register with skid entry for decoded words
// depends on utf8d_pkg and assert_macros.svh
`include "assert_macros.svh"
module utf8d_out_stage import utf8d_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_res,
    output logic    up_ready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_res
);

    logic    main_v_reg, main_v_next;
    logic    skid_v_reg, skid_v_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;

    // ready comes straight from a register
    assign up_ready = !skid_v_reg;

    always_comb begin
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        main_next   = main_reg;
        skid_next   = skid_reg;
        if (m_tready || !main_v_reg) begin
            if (skid_v_reg) begin
                main_next   = skid_reg;
                main_v_next = 1'b1;
                skid_v_next = 1'b0;
            end else begin
                main_next   = push_res;
                main_v_next = push;
            end
        end else if (push) begin
            skid_next   = push_res;
            skid_v_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = main_v_reg;
    assign m_res    = main_reg;

    // checks on the skid entry
    `UTF8D_ASSERT(a_skid_needs_main, aclk, aresetn, skid_v_reg |-> main_v_reg)
    `UTF8D_NEVER(a_push_when_full, aclk, aresetn, push && skid_v_reg)
    `UTF8D_ASSERT(a_skid_on_stall, aclk, aresetn,
                  $rose(skid_v_reg) |-> $past(main_v_reg && !m_tready))

endmodule

>>> src/utf8_stream_decoder.sv
// utf8 stream decoder, top level
// depends on utf8d_pkg, utf8d_in_stage, utf8d_core, utf8d_out_stage
//
// Decodes the original one-to-six-byte UTF-8 form, one byte per word.
// Input channel s_*: s_tdata[7:0] is the byte, s_tlast marks the final
// byte of the stream. Result channel m_*: m_tdata carries the code point
// and the sequence length, m_tuser the status (ok, bad lead, bad
// continuation, truncated). A result appears when a character completes,
// on any error, and when the stream ends inside a sequence; other bytes
// give no result. Errors drop the partial sequence and the offending byte.
// Throughput is one byte per cycle while the receiver keeps up. A result
// word passes the input register, the decode and the output register
// before m_tvalid rises; a stall can hold its byte in the input register.
// A stalled receiver first fills the skid entry behind the output
// register; s_tready then drops until the result words drain.
// Reset (aresetn low, synchronous) empties both registers and returns the
// decoder to the idle state with no partial sequence.
module utf8_stream_decoder import utf8d_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] in_byte
    input  logic                 s_tlast,   // end_of_input
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OutTdataW-1:0] m_tdata,   // [30:0] code_point, [33:31] seq_length
    output logic [1:0]           m_tuser    // [1:0] status
);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    logic     down_ready;
    logic     res_valid;
    result_t  res;
    result_t  m_res;

    assign s_item.in_byte      = s_tdata;
    assign s_item.end_of_input = s_tlast;

    // input register
    utf8d_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .down_ready (down_ready),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance)
    );

    // decode and sequence state
    utf8d_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    utf8d_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (advance && item_valid && res_valid),
        .push_res (res),
        .up_ready (down_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    // pack the result word
    assign m_tdata = {{(OutTdataW-OutPayload){1'b0}}, m_res.seq_length, m_res.code_point};
    assign m_tuser = m_res.status;

endmodule

>>> sim/testbench.sv
// self-checking bench for utf8_stream_decoder: directed table, then random byte streams
// depends on utf8d_pkg and the decoder rtl; expected words come from a local decode model
`timescale 1ns / 1ps

module testbench;
    import utf8d_pkg::*;

    localparam int unsigned RandomBytes = 2000;
    localparam int unsigned LongHold    = 400;
    localparam int unsigned StallLimit  = 4000;
    localparam int unsigned DrainCycles = 16;

    // one row of the directed table; fixed rows carry a hand-written expectation
    typedef struct packed {
        logic [7:0] in_byte;
        bit         last;
        bit         fixed;
        result_t    want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OutTdataW-1:0] m_tdata;
    logic [1:0]           m_tuser;

    // decode model state
    logic [CpWidth-1:0]  dec_acc;
    logic [LenWidth-1:0] dec_left;
    logic [LenWidth-1:0] dec_len;

    result_t     pending_chars[$];
    dir_row_t    directed_rows[$];
    int unsigned fail_count;
    int unsigned bytes_sent;
    int unsigned quiet_cycles;
    bit          idle_free;
    bit          hold_off_req;

    utf8_stream_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // mostly short gaps, now and then a long one, none during an idle-free stretch
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (idle_free || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // decode one byte; returns 1 when a result word is due
    function automatic bit decode_byte(input logic [7:0] b, input bit last,
                                       output result_t res);
        int unsigned         ones;
        logic [LenWidth-1:0] seen;
        res = '{code_point: '0, seq_length: 3'd1, status: ST_OK};
        if (dec_left == 0) begin
            ones = 0;
            while (ones < 8 && b[7 - ones])
                ones++;
            if (ones == 0) begin
                res.code_point = CpWidth'(b);
                return 1'b1;
            end
            if (ones == 1 || ones > 6) begin
                res.status = ST_BAD_LEAD;
                return 1'b1;
            end
            if (last) begin
                res.status = ST_TRUNC;
                return 1'b1;
            end
            dec_acc  = CpWidth'(b & (8'h7f >> ones));
            dec_left = LenWidth'(ones - 1);
            dec_len  = LenWidth'(ones);
            return 1'b0;
        end
        seen = dec_len - dec_left;
        if (b[7:6] != 2'b10) begin
            res.status     = ST_BAD_CONT;
            res.seq_length = seen + 3'd1;
            dec_acc  = '0;
            dec_left = '0;
            dec_len  = '0;
            return 1'b1;
        end
        dec_acc  = {dec_acc[CpWidth-7:0], b[5:0]};
        dec_left = dec_left - 3'd1;
        if (dec_left == 0) begin
            res.code_point = dec_acc;
            res.seq_length = dec_len;
        end else if (last) begin
            res.status     = ST_TRUNC;
            res.seq_length = seen + 3'd1;
        end else begin
            return 1'b0;
        end
        dec_acc  = '0;
        dec_left = '0;
        dec_len  = '0;
        return 1'b1;
    endfunction

    // offer one word, wait for the handshake, then record what should come out
    task automatic send_byte(input logic [7:0] b, input bit last, input bit fixed,
                             input result_t want);
        int unsigned gap;
        result_t     res;
        bit          due;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        due = decode_byte(b, last, res);
        if (fixed)
            pending_chars.push_back(want);
        else if (due)
            pending_chars.push_back(res);
        bytes_sent++;
    endtask

    task automatic send_rand(input logic [7:0] b, input bit last);
        send_byte(b, last, 1'b0, '0);
    endtask

    task automatic add_row(input logic [7:0] b, input bit last, input bit fixed,
                           input logic [CpWidth-1:0] cp, input logic [2:0] len,
                           input status_t st);
        directed_rows.push_back('{in_byte: b, last: last, fixed: fixed,
                                  want: '{code_point: cp, seq_length: len, status: st}});
    endtask

    // one random character: mostly well formed, some broken, some pure noise
    task automatic send_sequence();
        int unsigned kind;
        int unsigned n;
        int unsigned bad_at;
        logic [7:0]  b;
        bit          last;
        kind = $urandom_range(0, 99);
        if (kind >= 88) begin
            repeat ($urandom_range(1, 4))
                send_rand(8'($urandom), $urandom_range(0, 3) == 0);
            return;
        end
        n = $urandom_range(1, 6);
        bad_at = (kind >= 73 && n > 1) ? $urandom_range(1, n - 1) : 0;
        if (kind >= 73 && n == 1) begin
            // broken single byte: a stray continuation or one of the two illegal leads
            b = ($urandom_range(0, 3) == 0) ? {7'h7f, 1'($urandom)} : {2'b10, 6'($urandom)};
            send_rand(b, $urandom_range(0, 24) == 0);
            return;
        end
        for (int unsigned i = 0; i < n; i++) begin
            if (i == 0)
                b = (n == 1) ? {1'b0, 7'($urandom)}
                             : 8'(8'hff << (8 - n)) | (8'($urandom) & (8'h7f >> n));
            else if (i == bad_at)
                do b = 8'($urandom); while (b[7:6] == 2'b10);
            else
                b = {2'b10, 6'($urandom)};
            last = $urandom_range(0, 24) == 0;
            send_rand(b, last);
            if (last || (bad_at != 0 && i == bad_at))
                break;
        end
    endtask

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string what, input result_t want,
                                   input result_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected cp %h len %0d status %s, got cp %h len %0d status %s",
                     $realtime, what, want.code_point, want.seq_length, want.status.name(),
                     got.code_point, got.seq_length, got.status.name());
    endtask

    // compare each result word with the oldest expectation
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.code_point = m_tdata[CpWidth-1:0];
            got.seq_length = m_tdata[OutPayload-1:CpWidth];
            got.status     = status_t'(m_tuser);
            if (pending_chars.size() == 0) begin
                report_mismatch("result word with nothing pending", '0, got);
            end else begin
                want = pending_chars.pop_front();
                if (got.code_point !== want.code_point || got.seq_length !== want.seq_length
                        || got.status !== want.status)
                    report_mismatch("result word mismatch", want, got);
            end
        end
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin : result_sink
        int unsigned gap;
        m_tready = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                gap = LongHold;
            end else begin
                gap = pick_gap();
            end
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // stimulus
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        dec_acc      = '0;
        dec_left     = '0;
        dec_len      = '0;
        fail_count   = 0;
        bytes_sent   = 0;
        quiet_cycles = 0;
        idle_free    = 1'b0;
        hold_off_req = 1'b0;

        // single bytes at the extremes and the illegal leads
        add_row(8'h00, 1'b0, 1'b1, 31'h0, 3'd1, ST_OK);
        add_row(8'h7f, 1'b0, 1'b1, 31'h7f, 3'd1, ST_OK);
        add_row(8'h80, 1'b0, 1'b1, 31'h0, 3'd1, ST_BAD_LEAD);
        add_row(8'hfe, 1'b0, 1'b1, 31'h0, 3'd1, ST_BAD_LEAD);
        add_row(8'hff, 1'b0, 1'b1, 31'h0, 3'd1, ST_BAD_LEAD);
        // two and three byte characters
        add_row(8'hc3, 1'b0, 1'b0, '0, 3'd0, ST_OK);
        add_row(8'ha9, 1'b0, 1'b0, '0, 3'd0, ST_OK);
        add_row(8'he2, 1'b0, 1'b0, '0, 3'd0, ST_OK);
        add_row(8'h82, 1'b0, 1'b0, '0, 3'd0, ST_OK);
        add_row(8'hac, 1'b0, 1'b0, '0, 3'd0, ST_OK);
        // six byte form, all payload bits set
        add_row(8'hfd, 1'b0, 1'b0, '0, 3'd0, ST_OK);
        repeat (4) add_row(8'hbf, 1'b0, 1'b0, '0, 3'd0, ST_OK);
        add_row(8'hbf, 1'b0, 1'b1, 31'h7fffffff, 3'd6, ST_OK);
        // bad continuation
        add_row(8'hc3, 1'b0, 1'b0, '0, 3'd0, ST_OK);
        add_row(8'h41, 1'b0, 1'b1, 31'h0, 3'd2, ST_BAD_CONT);
        // truncation on a lead and on a continuation
        add_row(8'he2, 1'b1, 1'b1, 31'h0, 3'd1, ST_TRUNC);
        add_row(8'he2, 1'b0, 1'b0, '0, 3'd0, ST_OK);
        add_row(8'h82, 1'b1, 1'b1, 31'h0, 3'd2, ST_TRUNC);
        // bad continuation wins over end of input
        add_row(8'hc3, 1'b0, 1'b0, '0, 3'd0, ST_OK);
        add_row(8'hc3, 1'b1, 1'b1, 31'h0, 3'd2, ST_BAD_CONT);
        // end of input while idle
        add_row(8'h41, 1'b1, 1'b1, 31'h41, 3'd1, ST_OK);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].in_byte, directed_rows[i].last,
                      directed_rows[i].fixed, directed_rows[i].want);

        // random streams; the sink holds off once early on so the input backs up
        hold_off_req = 1'b1;
        while (bytes_sent < directed_rows.size() + RandomBytes) begin
            if ($urandom_range(0, 39) == 0)
                idle_free = ~idle_free;
            send_sequence();
        end
        idle_free = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        if (fail_count == 0 && pending_chars.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/utf8d_pkg.sv
src/utf8d_in_stage.sv
src/utf8d_core.sv
src/utf8d_out_stage.sv
src/utf8_stream_decoder.sv
sim/testbench.sv
